// ===== hdl/dxt_pkg.sv =====
// Shared types, widths and arithmetic helpers for the DXT block decoder.
package dxt_pkg;

  localparam int unsigned STRIDE_W = 13;
  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned COORD_W  = 12;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_e;

  // 5- and 6-bit endpoint widening by bit replication
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // x / 3 for x < 768 via reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // x / 7 for x < 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // x / 5 for x < 1280
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  // (2a + b + 1) / 3
  function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
    return div3(10'({a, 1'b0}) + 10'(b) + 10'd1);
  endfunction

  // (a + b + 1) / 2
  function automatic logic [7:0] midpoint(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b) + 9'd1;
    return s[8:1];
  endfunction

endpackage

// ===== hdl/dxt_block_decoder.sv =====
// DXT1/DXT3/DXT5 4x4 block decoder emitting one RGBA pixel per cycle.
//
// Command channel: an item (format, color block, alpha block, block x/y)
// is taken at a clock edge where start_i is high and busy_o is low.
// Config channel: cfg_data_i is written to the image stride at an edge
// where cfg_valid_i and cfg_ready_o are high; cfg_ready_o is always high.
// Result channel: each pixel is on the result ports for one cycle with
// result_strobe_o high; 16 pixels per item in raster order, last_o on the
// sixteenth. The receiver cannot stall the block.
// An accepted item waits in the input stage until the decoded stage is
// free; each pixel leaves through the result register. The single pixel
// output port sets the pace; the palette/alpha-table stage decodes the
// next item while the current one emits, so pixels stream without gaps.
// Reset clears all valid flags and sets the stride to 256.
module dxt_block_decoder #(
  parameter int unsigned MAX_IMAGE_SIDE = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     op_i,
  input  logic [63:0]                    color_block_i,
  input  logic [63:0]                    alpha_block_i,
  input  logic [dxt_pkg::COORD_W-1:0]    block_x_i,
  input  logic [dxt_pkg::COORD_W-1:0]    block_y_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dxt_pkg::STRIDE_W-1:0]   cfg_data_i,
  output logic                           result_strobe_o,
  output logic [dxt_pkg::ADDR_W-1:0]     pixel_addr_o,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [7:0]                     alpha_o,
  output logic                           last_o
);
  import dxt_pkg::*;

  localparam logic [31:0] MaxSide = 32'(MAX_IMAGE_SIDE);

  // config
  logic [STRIDE_W-1:0] stride_q;
  logic [STRIDE_W-1:0] stride_eff;

  // input stage
  logic                a_valid_q, a_valid_d;
  logic [1:0]          a_op_q;
  logic [63:0]         a_color_q;
  logic [63:0]         a_alpha_q;
  logic [COORD_W-1:0]  a_x_q;
  logic [COORD_W-1:0]  a_y_q;

  // decoded stage
  logic                b_valid_q, b_valid_d;
  logic [3:0]          b_cnt_q, b_cnt_d;
  logic [1:0]          b_op_q;
  logic                b_three_q;
  logic [31:0]         b_idx_q;
  logic [63:0]         b_alpha_q;
  logic [7:0]          b_pal_q [4][3];
  logic [7:0]          b_atab_q [8];
  logic [ADDR_W-1:0]   b_row_q, b_row_d;

  // result register
  logic                res_valid_q;
  logic [ADDR_W-1:0]   res_addr_q;
  logic [7:0]          res_r_q, res_g_q, res_b_q, res_a_q;
  logic                res_last_q;

  logic accept, a_to_b, b_done;

  // decode logic
  logic [15:0] c0, c1;
  logic        three;
  logic [7:0]  e0 [3];
  logic [7:0]  e1 [3];
  logic [7:0]  pal_d [4][3];
  logic [7:0]  atab_d [8];
  logic [7:0]  a0, a1;
  logic [COORD_W+STRIDE_W-1:0] row_prod;

  // per-pixel logic
  logic [1:0]  ci;
  logic [3:0]  nib;
  logic [2:0]  aidx;
  logic [7:0]  pix_a;

  always_comb begin
    if (stride_q == '0) begin
      stride_eff = STRIDE_W'(1);
    end else if (32'(stride_q) > MaxSide) begin
      stride_eff = STRIDE_W'(MaxSide);
    end else begin
      stride_eff = stride_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign b_done      = b_valid_q && (b_cnt_q == 4'd15);
  assign a_to_b      = a_valid_q && (!b_valid_q || b_done);
  assign busy_o      = a_valid_q && !a_to_b;
  assign accept      = start_i && !busy_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (a_to_b) begin
      a_valid_d = 1'b0;
    end
  end

  // palette and alpha table
  always_comb begin
    c0    = a_color_q[15:0];
    c1    = a_color_q[31:16];
    three = (a_op_q == FMT_DXT1) && (c0 <= c1);
    e0[0] = widen5(c0[15:11]);
    e0[1] = widen6(c0[10:5]);
    e0[2] = widen5(c0[4:0]);
    e1[0] = widen5(c1[15:11]);
    e1[1] = widen6(c1[10:5]);
    e1[2] = widen5(c1[4:0]);
    for (int ch = 0; ch < 3; ch++) begin
      pal_d[0][ch] = e0[ch];
      pal_d[1][ch] = e1[ch];
      if (three) begin
        pal_d[2][ch] = midpoint(e0[ch], e1[ch]);
        pal_d[3][ch] = 8'd0;
      end else begin
        pal_d[2][ch] = third(e0[ch], e1[ch]);
        pal_d[3][ch] = third(e1[ch], e0[ch]);
      end
    end

    a0 = a_alpha_q[7:0];
    a1 = a_alpha_q[15:8];
    atab_d[0] = a0;
    atab_d[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) begin
        atab_d[i+1] = div7(11'(4'(7 - i)) * 11'(a0) + 11'(4'(i)) * 11'(a1) + 11'd3);
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        atab_d[i+1] = div5(11'(4'(5 - i)) * 11'(a0) + 11'(4'(i)) * 11'(a1) + 11'd2);
      end
      atab_d[6] = 8'd0;
      atab_d[7] = 8'd255;
    end

    row_prod = (COORD_W+STRIDE_W)'(a_y_q) * (COORD_W+STRIDE_W)'(stride_eff);
  end

  always_comb begin
    b_valid_d = b_valid_q;
    b_cnt_d   = b_cnt_q;
    b_row_d   = b_row_q;
    if (a_to_b) begin
      b_valid_d = 1'b1;
      b_cnt_d   = 4'd0;
      b_row_d   = ADDR_W'(row_prod) + ADDR_W'(a_x_q);
    end else if (b_valid_q) begin
      b_cnt_d = b_cnt_q + 4'd1;
      if (b_done) begin
        b_valid_d = 1'b0;
      end
      if (b_cnt_q[1:0] == 2'd3) begin
        b_row_d = b_row_q + ADDR_W'(stride_eff);
      end
    end
  end

  // pixel select
  always_comb begin
    ci   = b_idx_q[{b_cnt_q, 1'b0} +: 2];
    nib  = b_alpha_q[{b_cnt_q, 2'b00} +: 4];
    aidx = b_alpha_q[6'd16 + 6'(b_cnt_q) * 6'd3 +: 3];
    case (b_op_q)
      FMT_DXT1: begin
        pix_a = (b_three_q && ci == 2'd3) ? 8'd0 : 8'd255;
      end
      FMT_DXT3: begin
        pix_a = {nib, nib};
      end
      default: begin
        pix_a = b_atab_q[aidx];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q    <= STRIDE_W'(256);
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      b_cnt_q     <= 4'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        stride_q <= cfg_data_i;
      end
      a_valid_q   <= a_valid_d;
      b_valid_q   <= b_valid_d;
      b_cnt_q     <= b_cnt_d;
      res_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q    <= op_i;
      a_color_q <= color_block_i;
      a_alpha_q <= alpha_block_i;
      a_x_q     <= block_x_i;
      a_y_q     <= block_y_i;
    end
    b_row_q <= b_row_d;
    if (a_to_b) begin
      b_op_q    <= a_op_q;
      b_three_q <= three;
      b_idx_q   <= a_color_q[63:32];
      b_alpha_q <= a_alpha_q;
      b_pal_q   <= pal_d;
      b_atab_q  <= atab_d;
    end
    res_addr_q <= b_row_q + ADDR_W'(b_cnt_q[1:0]);
    res_r_q    <= b_pal_q[ci][0];
    res_g_q    <= b_pal_q[ci][1];
    res_b_q    <= b_pal_q[ci][2];
    res_a_q    <= pix_a;
    res_last_q <= (b_cnt_q == 4'd15);
  end

  assign result_strobe_o = res_valid_q;
  assign pixel_addr_o    = res_addr_q;
  assign red_o           = res_r_q;
  assign green_o         = res_g_q;
  assign blue_o          = res_b_q;
  assign alpha_o         = res_a_q;
  assign last_o          = res_last_q;

endmodule

// ===== sim/tb_dxt_block_decoder.sv =====
// Self-checking testbench for the DXT block decoder: predicted pixels against RTL output.
module tb_dxt_block_decoder;
  import dxt_pkg::*;

  localparam int MAX_SIDE         = 4096;
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int RANDOM_PER_PHASE = 29;
  localparam int NUM_PHASES       = 7;
  localparam logic [1:0] FMT_ALIAS5 = 2'd3;  // decodes as DXT5

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic              last;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t              expected_pixels[$];
    logic [STRIDE_W-1:0] stride;
    int                  errors;
    int                  blocks;
    int                  pixels;

    function new();
      stride = 13'd256;
      errors = 0;
      blocks = 0;
      pixels = 0;
    endfunction

    // Decode one block into its 16 expected pixels.
    function void note_block(logic [1:0] op, logic [63:0] cb, logic [63:0] ab,
                             logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
      logic [15:0] c0, c1;
      int          e0[3], e1[3];
      int          pal[4][4];
      int          atab[8];
      int          a0, a1, s, ch, i, row, col, ci, alpha, addr;
      pixel_t      px;
      c0 = cb[15:0];
      c1 = cb[31:16];
      s = stride;
      if (s == 0) s = 1;
      if (s > MAX_SIDE) s = MAX_SIDE;
      e0[0] = {c0[15:11], c0[15:13]};
      e0[1] = {c0[10:5], c0[10:9]};
      e0[2] = {c0[4:0], c0[4:2]};
      e1[0] = {c1[15:11], c1[15:13]};
      e1[1] = {c1[10:5], c1[10:9]};
      e1[2] = {c1[4:0], c1[4:2]};
      for (ch = 0; ch < 4; ch++) pal[ch][3] = 255;
      for (ch = 0; ch < 3; ch++) begin
        pal[0][ch] = e0[ch];
        pal[1][ch] = e1[ch];
        if (op == FMT_DXT1 && c0 <= c1) begin
          pal[2][ch] = (e0[ch] + e1[ch] + 1) / 2;
          pal[3][ch] = 0;
        end else begin
          pal[2][ch] = (2 * e0[ch] + e1[ch] + 1) / 3;
          pal[3][ch] = (2 * e1[ch] + e0[ch] + 1) / 3;
        end
      end
      if (op == FMT_DXT1 && c0 <= c1) pal[3][3] = 0;

      a0 = ab[7:0];
      a1 = ab[15:8];
      atab[0] = a0;
      atab[1] = a1;
      if (a0 > a1) begin
        for (i = 1; i <= 6; i++) atab[i + 1] = ((7 - i) * a0 + i * a1 + 3) / 7;
      end else begin
        for (i = 1; i <= 4; i++) atab[i + 1] = ((5 - i) * a0 + i * a1 + 2) / 5;
        atab[6] = 0;
        atab[7] = 255;
      end

      for (i = 0; i < 16; i++) begin
        row = i / 4;
        col = i % 4;
        ci = cb[32 + 2 * i +: 2];
        if (op == FMT_DXT1) alpha = pal[ci][3];
        else if (op == FMT_DXT3) alpha = ab[4 * i +: 4] * 17;
        else alpha = atab[ab[16 + 3 * i +: 3]];
        addr = (int'(by) + row) * s + int'(bx) + col;
        px.addr  = ADDR_W'(addr);
        px.red   = 8'(pal[ci][0]);
        px.green = 8'(pal[ci][1]);
        px.blue  = 8'(pal[ci][2]);
        px.alpha = 8'(alpha);
        px.last  = (i == 15);
        expected_pixels.push_back(px);
      end
      blocks++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("pixel at address %0d with no block pending", got.addr);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        pixels++;
        compare_field("pixel_addr", want.addr, got.addr);
        compare_field("red", want.red, got.red);
        compare_field("green", want.green, got.green);
        compare_field("blue", want.blue, got.blue);
        compare_field("alpha", want.alpha, got.alpha);
        compare_field("last", want.last, got.last);
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start_i       = 1'b0;
  logic [1:0]          op_i          = '0;
  logic [63:0]         color_block_i = '0;
  logic [63:0]         alpha_block_i = '0;
  logic [COORD_W-1:0]  block_x_i     = '0;
  logic [COORD_W-1:0]  block_y_i     = '0;
  logic                cfg_valid_i   = 1'b0;
  logic [STRIDE_W-1:0] cfg_data_i    = '0;
  logic                busy_o;
  logic                cfg_ready_o;
  logic                result_strobe_o;
  logic [ADDR_W-1:0]   pixel_addr_o;
  logic [7:0]          red_o;
  logic [7:0]          green_o;
  logic [7:0]          blue_o;
  logic [7:0]          alpha_o;
  logic                last_o;

  pixel_scoreboard     sb;
  int                  idle_cycles = 0;
  logic [STRIDE_W-1:0] stride_set[NUM_PHASES] =
    '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd256, 13'd3, 13'd640};
  int                  idle_pct[3] = '{0, 73, 28};

  dxt_block_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .color_block_i   (color_block_i),
    .alpha_block_i   (alpha_block_i),
    .block_x_i       (block_x_i),
    .block_y_i       (block_y_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .pixel_addr_o    (pixel_addr_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : monitor
    pixel_t got;
    logic   progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        sb.note_block(op_i, color_block_i, alpha_block_i, block_x_i, block_y_i);
        progress = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.stride = cfg_data_i;
        progress = 1'b1;
      end
      if (result_strobe_o) begin
        got.addr  = pixel_addr_o;
        got.red   = red_o;
        got.green = green_o;
        got.blue  = blue_o;
        got.alpha = alpha_o;
        got.last  = last_o;
        sb.check_pixel(got);
        progress = 1'b1;
      end
    end
    idle_cycles <= progress ? 0 : idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $error("no activity for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_block(logic [1:0] op, logic [63:0] cb, logic [63:0] ab,
                            logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
    op_i          <= op;
    color_block_i <= cb;
    alpha_block_i <= ab;
    block_x_i     <= bx;
    block_y_i     <= by;
    start_i       <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_sender(int pct);
    if ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_stride(logic [STRIDE_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(3))
      0:       return COORD_W'($urandom);
      3:       return $urandom_range(1) ? '1 : '0;
      default: return {10'($urandom_range(0, 1023)), 2'b00};
    endcase
  endfunction

  task automatic random_block();
    logic [1:0]  op;
    logic [63:0] cb, ab;
    op = ($urandom_range(9) == 0) ? FMT_ALIAS5 : 2'($urandom_range(0, 2));
    cb = {$urandom, $urandom};
    ab = {$urandom, $urandom};
    // bias endpoints toward equal, near and extreme pairs
    case ($urandom_range(3))
      0: cb[31:16] = cb[15:0];
      1: cb[31:16] = cb[15:0] ^ 16'(1 << $urandom_range(15));
      2: cb[31:16] = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      default: ;
    endcase
    case ($urandom_range(3))
      0: ab[15:8] = ab[7:0];
      1: ab[15:8] = ab[7:0] ^ 8'(1 << $urandom_range(7));
      2: ab[15:8] = $urandom_range(1) ? 8'h00 : 8'hFF;
      default: ;
    endcase
    send_block(op, cb, ab, random_coord(), random_coord());
  endtask

  initial begin : stimulus
    logic [47:0] ramp;
    int          k, phase, n;
    sb = new();
    for (k = 0; k < 16; k++) ramp[3 * k +: 3] = 3'(k);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // four-color, three-color, equal endpoints, transparent
    send_block(FMT_DXT1, {32'hE4E4E4E4, 16'h0000, 16'hFFFF}, 64'h0, 12'd0, 12'd0);
    send_block(FMT_DXT1, {32'hE4E4E4E4, 16'hFFFF, 16'h0000}, '1, 12'd4, 12'd0);
    send_block(FMT_DXT1, {32'h1B1B1B1B, 16'h1234, 16'h1234}, 64'h0, 12'd8, 12'd4);
    send_block(FMT_DXT1, {32'hFFFFFFFF, 16'h0000, 16'h0000}, 64'h0, 12'd12, 12'd8);
    send_block(FMT_DXT1, '1, '1, '1, '1);
    send_block(FMT_DXT1, '0, '0, '0, '0);
    // explicit alpha
    send_block(FMT_DXT3, {32'hE4E4E4E4, 16'h07E0, 16'hF800}, 64'hFEDCBA9876543210,
               12'd16, 12'd0);
    send_block(FMT_DXT3, {32'h4E4E4E4E, 16'hF800, 16'h001F}, '1, 12'd20, 12'd4);
    send_block(FMT_DXT3, '1, '0, 12'd4092, 12'd0);
    send_block(FMT_DXT3, '0, '1, 12'd0, 12'd4092);
    // interpolated alpha, eight- and six-step tables
    send_block(FMT_DXT5, {32'hE4E4E4E4, 16'h001F, 16'hF800}, {ramp, 8'h00, 8'hFF},
               12'd24, 12'd0);
    send_block(FMT_DXT5, {32'h39393939, 16'hF800, 16'h07E0}, {ramp, 8'hFF, 8'h00},
               12'd28, 12'd0);
    send_block(FMT_DXT5, {32'h93939393, 16'h8410, 16'h8410}, {ramp, 8'h80, 8'h80},
               12'd32, 12'd0);
    send_block(FMT_DXT5, {32'hB1B1B1B1, 16'h2222, 16'hDDDD}, {ramp, 8'h10, 8'hF0},
               12'd36, 12'd0);
    send_block(FMT_DXT5, '1, '1, 12'd4092, 12'd4092);
    send_block(FMT_DXT5, '0, '0, 12'd0, 12'd0);
    // format code three
    send_block(FMT_ALIAS5, {32'hE4E4E4E4, 16'h0000, 16'hFFFF}, {ramp, 8'h00, 8'hFF},
               12'd40, 12'd0);
    send_block(FMT_ALIAS5, {32'h1B1B1B1B, 16'hFFFF, 16'h0000}, {ramp, 8'hFF, 8'h00},
               12'd44, 12'd0);

    stride_set[4] = STRIDE_W'($urandom_range(1, MAX_SIDE));
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drain();
      write_stride(stride_set[phase]);
      if (stride_set[phase] == MAX_SIDE) begin
        // address wraps past 2^24
        send_block(FMT_DXT1, {32'hE4E4E4E4, 16'h0000, 16'hFFFF}, '0, '1, '1);
        send_block(FMT_DXT5, {32'h1B1B1B1B, 16'hFFFF, 16'h0000}, {ramp, 8'h00, 8'hFF},
                   12'd4092, 12'd4092);
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        random_block();
        idle_sender(idle_pct[phase % 3]);
      end
    end

    wait_drain();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d pixels from %0d blocks in DXT1, DXT3, DXT5 and format code 3,",
             sb.pixels, sb.blocks);
    $display("across %0d stride settings including 0, 1, 4096 and 8191.", NUM_PHASES + 1);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.expected_pixels.size() != 0)
        $error("%0d expected pixels never arrived", sb.expected_pixels.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
